FILE: hdl/utf8_code_point_decoder_core_defines.svh
// assertion macros for the utf-8 decoder core
// each macro expects i_clk and i_rst_n in the scope where it is used
`ifndef UTF8_CODE_POINT_DECODER_CORE_DEFINES_SVH
`define UTF8_CODE_POINT_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define U8D_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("u8dec assertion failed");

`define U8D_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("u8dec assertion failed");

`else

`define U8D_ASSERT(label, prop)

`define U8D_ASSERT_NEXT(label, cond, prop)

`endif

`endif

FILE: hdl/u8dec_pkg.sv
package u8dec_pkg;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam logic [9:0] SURR_TOP  = 10'h01B;

    localparam logic [2:0] LEN_1 = 3'd1;
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

    localparam logic [20:0] MIN_LEN_2 = 21'h000080;
    localparam logic [20:0] MIN_LEN_3 = 21'h000800;
    localparam logic [20:0] MIN_LEN_4 = 21'h010000;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } t_in_req;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  seq_length;
        logic        bad_sequence;
    } t_out_req;

    // after lead classification
    typedef struct packed {
        logic [2:0] len;
        logic       stray;
        logic       cont_err;
        logic [6:0] lead;
        logic [5:0] pay1;
        logic [5:0] pay2;
        logic [5:0] pay3;
    } t_cls;

    // after code point assembly
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  len;
        logic        stray;
        logic        cont_err;
    } t_asm;

endpackage

FILE: hdl/utf8_code_point_decoder_core.sv
// utf-8 code point decoder: each request carries a four-byte window whose first
// byte is a lead byte; the core returns the assembled code point, the number of
// bytes the sequence uses (1 to 4) and one error flag covering a missing 10
// continuation prefix, an overlong form, a surrogate value or a stray
// continuation lead (which gives its low six bits and length 1). leads f8..ff
// decode as four-byte leads using their low three bits, and values above 10ffff
// pass without error. the core is a three-stage pipeline (classify, assemble,
// check) and takes one request every cycle while no stall holds it; a taken
// request is registered by the classify, assemble and check stages in turn,
// and each stage holds its request while the next one is full and stalled, so a
// stall at the output backs up stage by stage with nothing dropped.
module utf8_code_point_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  u8dec_pkg::t_in_req  i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output u8dec_pkg::t_out_req o_rsp
);
    import u8dec_pkg::*;

    // classify to assemble
    logic cls_valid;
    logic cls_ready;
    t_cls cls_data;

    // assemble to check
    logic asm_valid;
    logic asm_ready;
    t_asm asm_data;

    // stage 1: lead class, length, continuation prefix checks
    u8dec_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (cls_valid),
        .i_ready (cls_ready),
        .o_cls   (cls_data)
    );

    // stage 2: payload bits packed into the code point
    u8dec_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cls_valid),
        .o_ready (cls_ready),
        .i_cls   (cls_data),
        .o_valid (asm_valid),
        .i_ready (asm_ready),
        .o_asm   (asm_data)
    );

    // stage 3: overlong and surrogate checks, output register
    u8dec_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (asm_valid),
        .o_ready (asm_ready),
        .i_asm   (asm_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: hdl/u8dec_classify.sv
module u8dec_classify (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  u8dec_pkg::t_in_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output u8dec_pkg::t_cls   o_cls
);
    import u8dec_pkg::*;

    logic r_valid;
    t_cls r_data;
    t_cls n_data;
    logic nc1;
    logic nc2;
    logic nc3;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_data;

    always_comb begin
        nc1 = (i_req.byte1 & CONT_MASK) != CONT_MARK;
        nc2 = (i_req.byte2 & CONT_MASK) != CONT_MARK;
        nc3 = (i_req.byte3 & CONT_MASK) != CONT_MARK;
        n_data.pay1 = i_req.byte1[5:0];
        n_data.pay2 = i_req.byte2[5:0];
        n_data.pay3 = i_req.byte3[5:0];
        if (i_req.byte0 inside {[8'h00:8'h7F]}) begin
            n_data.len      = LEN_1;
            n_data.stray    = 1'b0;
            n_data.cont_err = 1'b0;
            n_data.lead     = i_req.byte0[6:0];
        end else if (i_req.byte0 inside {[8'h80:8'hBF]}) begin
            n_data.len      = LEN_1;
            n_data.stray    = 1'b1;
            n_data.cont_err = 1'b0;
            n_data.lead     = {1'b0, i_req.byte0[5:0]};
        end else if (i_req.byte0 inside {[8'hC0:8'hDF]}) begin
            n_data.len      = LEN_2;
            n_data.stray    = 1'b0;
            n_data.cont_err = nc1;
            n_data.lead     = {2'b00, i_req.byte0[4:0]};
        end else if (i_req.byte0 inside {[8'hE0:8'hEF]}) begin
            n_data.len      = LEN_3;
            n_data.stray    = 1'b0;
            n_data.cont_err = nc1 | nc2;
            n_data.lead     = {3'b000, i_req.byte0[3:0]};
        end else begin
            // f8..ff fold onto the four-byte form
            n_data.len      = LEN_4;
            n_data.stray    = 1'b0;
            n_data.cont_err = nc1 | nc2 | nc3;
            n_data.lead     = {4'b0000, i_req.byte0[2:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: hdl/u8dec_assemble.sv
module u8dec_assemble (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  u8dec_pkg::t_cls i_cls,
    output logic            o_valid,
    input  logic            i_ready,
    output u8dec_pkg::t_asm o_asm
);
    import u8dec_pkg::*;

    logic r_valid;
    t_asm r_data;
    t_asm n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_asm   = r_data;

    always_comb begin
        n_data.len      = i_cls.len;
        n_data.stray    = i_cls.stray;
        n_data.cont_err = i_cls.cont_err;
        case (i_cls.len)
            LEN_1: begin
                n_data.code_point = {14'd0, i_cls.lead};
            end
            LEN_2: begin
                n_data.code_point = {10'd0, i_cls.lead[4:0], i_cls.pay1};
            end
            LEN_3: begin
                n_data.code_point = {5'd0, i_cls.lead[3:0], i_cls.pay1, i_cls.pay2};
            end
            default: begin
                n_data.code_point = {i_cls.lead[2:0], i_cls.pay1, i_cls.pay2, i_cls.pay3};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: hdl/u8dec_check.sv
module u8dec_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  u8dec_pkg::t_asm    i_asm,
    output logic               o_valid,
    input  logic               i_ready,
    output u8dec_pkg::t_out_req o_rsp
);
    import u8dec_pkg::*;

    `include "utf8_code_point_decoder_core_defines.svh"

    logic        r_valid;
    t_out_req    r_data;
    t_out_req    n_data;
    logic [20:0] minimum;
    logic        overlong;
    logic        surrogate;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rsp   = r_data;

    always_comb begin
        case (i_asm.len)
            LEN_2:   minimum = MIN_LEN_2;
            LEN_3:   minimum = MIN_LEN_3;
            LEN_4:   minimum = MIN_LEN_4;
            default: minimum = 21'd0;
        endcase
        overlong  = i_asm.code_point < minimum;
        surrogate = (i_asm.len != LEN_1) && (i_asm.code_point[20:11] == SURR_TOP);
        n_data.code_point   = i_asm.code_point;
        n_data.seq_length   = i_asm.len;
        n_data.bad_sequence = i_asm.stray | i_asm.cont_err | overlong | surrogate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    `U8D_ASSERT_NEXT(a_take_fills, i_valid && o_ready, r_valid)
    `U8D_ASSERT_NEXT(a_stall_keeps, r_valid && !i_ready, r_valid)
    `U8D_ASSERT_NEXT(a_ascii_clean, i_valid && o_ready && i_asm.len == LEN_1 && !i_asm.stray, !r_data.bad_sequence)
    `U8D_ASSERT(a_stray_short, !(i_valid && i_asm.stray) || i_asm.len == LEN_1)

endmodule

FILE: test/utf8_code_point_decoder_core_tb.sv
`timescale 1ns / 100ps

module utf8_code_point_decoder_core_tb;
    import u8dec_pkg::*;

    localparam int RANDOM_WINDOWS = 650;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_AT        = 60;     // response count at which the long hold starts
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 8;      // three-stage pipe plus margin

    // one row of the directed table; typed rows carry their own expected response
    typedef struct packed {
        t_in_req  win;
        logic     typed;
        t_out_req want;
    } t_row;

    localparam int N_ROWS = 24;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // ascii extremes, unneeded bytes ignored
        '{'{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{21'h000000, LEN_1, 1'b0}},
        '{'{8'h7F, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{21'h00007F, LEN_1, 1'b0}},
        '{'{8'h41, 8'h00, 8'hC0, 8'hFF}, 1'b1, '{21'h000041, LEN_1, 1'b0}},
        // stray continuation leads
        '{'{8'h80, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{21'h000000, LEN_1, 1'b1}},
        '{'{8'hBF, 8'h80, 8'h80, 8'h80}, 1'b1, '{21'h00003F, LEN_1, 1'b1}},
        // two-byte: overlong, smallest, largest, missing continuation
        '{'{8'hC0, 8'h80, 8'h00, 8'h00}, 1'b1, '{21'h000000, LEN_2, 1'b1}},
        '{'{8'hC2, 8'h80, 8'hFF, 8'hFF}, 1'b1, '{21'h000080, LEN_2, 1'b0}},
        '{'{8'hDF, 8'hBF, 8'h00, 8'h00}, 1'b1, '{21'h0007FF, LEN_2, 1'b0}},
        '{'{8'hC2, 8'h00, 8'h80, 8'h80}, 1'b1, '{21'h000080, LEN_2, 1'b1}},
        // three-byte: overlong, smallest, surrogate edges, largest, bad second continuation
        '{'{8'hE0, 8'h80, 8'h80, 8'h00}, 1'b1, '{21'h000000, LEN_3, 1'b1}},
        '{'{8'hE0, 8'hA0, 8'h80, 8'h00}, 1'b1, '{21'h000800, LEN_3, 1'b0}},
        '{'{8'hED, 8'hA0, 8'h80, 8'h00}, 1'b1, '{21'h00D800, LEN_3, 1'b1}},
        '{'{8'hED, 8'hBF, 8'hBF, 8'h00}, 1'b1, '{21'h00DFFF, LEN_3, 1'b1}},
        '{'{8'hEF, 8'hBF, 8'hBF, 8'hFF}, 1'b1, '{21'h00FFFF, LEN_3, 1'b0}},
        '{'{8'hE1, 8'h80, 8'h00, 8'h00}, 1'b1, '{21'h001000, LEN_3, 1'b1}},
        // four-byte: overlong, smallest, top of unicode, above it, largest, bad third continuation
        '{'{8'hF0, 8'h80, 8'h80, 8'h80}, 1'b1, '{21'h000000, LEN_4, 1'b1}},
        '{'{8'hF0, 8'h90, 8'h80, 8'h80}, 1'b1, '{21'h010000, LEN_4, 1'b0}},
        '{'{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1, '{21'h10FFFF, LEN_4, 1'b0}},
        '{'{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b1, '{21'h110000, LEN_4, 1'b0}},
        '{'{8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b1, '{21'h1FFFFF, LEN_4, 1'b0}},
        '{'{8'hF0, 8'h90, 8'h80, 8'hC0}, 1'b1, '{21'h010000, LEN_4, 1'b1}},
        // f8..ff leads keep only their low three bits
        '{'{8'hFF, 8'hBF, 8'hBF, 8'hBF}, 1'b1, '{21'h1FFFFF, LEN_4, 1'b0}},
        // everyday text, left to the predictor
        '{'{8'hE2, 8'h82, 8'hAC, 8'h20}, 1'b0, '0},
        '{'{8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b0, '0}
    };

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_in_req  i_req;
    logic     o_valid;
    logic     i_ready;
    t_out_req o_rsp;

    // responses still owed by the core, oldest first
    t_out_req pending_points [$];
    int       fail_count;
    int       cycle_count;
    int       decoded_total;
    int       flagged_total;
    int       length_seen [1:4];

    utf8_code_point_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic lacks_cont_prefix(input logic [7:0] b);
        return (b & CONT_MASK) != CONT_MARK;
    endfunction

    // predictor: what the core should return for one window
    function automatic t_out_req decode_window(input t_in_req w);
        t_out_req    rsp;
        logic [20:0] least;
        least = '0;
        if (!w.byte0[7]) begin
            // plain ascii, never in error
            rsp = '{{13'd0, w.byte0}, LEN_1, 1'b0};
        end else if (w.byte0[7:6] == 2'b10) begin
            // stray continuation lead
            rsp = '{{15'd0, w.byte0[5:0]}, LEN_1, 1'b1};
        end else if (w.byte0[7:5] == 3'b110) begin
            rsp = '{{10'd0, w.byte0[4:0], w.byte1[5:0]}, LEN_2, lacks_cont_prefix(w.byte1)};
            least = MIN_LEN_2;
        end else if (w.byte0[7:4] == 4'b1110) begin
            rsp = '{{5'd0, w.byte0[3:0], w.byte1[5:0], w.byte2[5:0]}, LEN_3,
                    lacks_cont_prefix(w.byte1) | lacks_cont_prefix(w.byte2)};
            least = MIN_LEN_3;
        end else begin
            // f0..ff, the top eight leads f8..ff too
            rsp = '{{w.byte0[2:0], w.byte1[5:0], w.byte2[5:0], w.byte3[5:0]}, LEN_4,
                    lacks_cont_prefix(w.byte1) | lacks_cont_prefix(w.byte2)
                    | lacks_cont_prefix(w.byte3)};
            least = MIN_LEN_4;
        end
        // overlong form
        if (rsp.code_point < least)
            rsp.bad_sequence = 1'b1;
        // surrogate range d800..dfff
        if (rsp.seq_length != LEN_1 && rsp.code_point[20:11] == SURR_TOP)
            rsp.bad_sequence = 1'b1;
        return rsp;
    endfunction

    // random window: mostly well-formed sequences with random payload,
    // the rest overlong, surrogate, broken or plain noise
    function automatic t_in_req make_window();
        t_in_req    w;
        int         pick;
        logic [1:0] bad_top;
        w    = $urandom;
        pick = $urandom_range(0, 99);
        // well-formed continuations by default, corrupted below where wanted
        w.byte1[7:6] = 2'b10;
        w.byte2[7:6] = 2'b10;
        w.byte3[7:6] = 2'b10;
        if (pick < 14) begin
            w.byte0[7] = 1'b0;
        end else if (pick < 30) begin
            w.byte0 = 8'($urandom_range(8'hC2, 8'hDF));
        end else if (pick < 46) begin
            w.byte0 = {4'b1110, w.byte0[3:0]};
        end else if (pick < 60) begin
            w.byte0 = 8'($urandom_range(8'hF0, 8'hF4));
        end else if (pick < 65) begin
            w.byte0 = {5'b11111, w.byte0[2:0]};
        end else if (pick < 70) begin
            w.byte0[7:6] = 2'b10;
        end else if (pick < 76) begin
            // overlong forms near each boundary
            case ($urandom_range(0, 2))
                0: w.byte0 = {7'b1100000, w.byte0[0]};
                1: begin w.byte0 = 8'hE0; w.byte1[5] = 1'b0; end
                default: begin w.byte0 = 8'hF0; w.byte1[5:4] = 2'b00; end
            endcase
        end else if (pick < 80) begin
            // surrogate
            w.byte0 = 8'hED;
            w.byte1[5] = 1'b1;
        end else if (pick < 90) begin
            // multi-byte lead with one continuation broken
            w.byte0[7:6] = 2'b11;
            bad_top = ($urandom_range(0, 2) == 2) ? 2'b11 : 2'($urandom_range(0, 1));
            case ($urandom_range(1, 3))
                1: w.byte1[7:6] = bad_top;
                2: w.byte2[7:6] = bad_top;
                default: w.byte3[7:6] = bad_top;
            endcase
        end else begin
            w = $urandom;
        end
        return w;
    endfunction

    // offer one request after the drawn gap and hold it until taken
    task automatic offer_window(input t_in_req win, input t_out_req want, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= win;
        do @(posedge i_clk); while (!o_ready);
        pending_points.push_back(want);
    endtask

    task automatic check_response(input t_out_req got);
        t_out_req want;
        if (pending_points.size() == 0) begin
            $error("unexpected response: code_point %h seq_length %0d bad_sequence %0d",
                   got.code_point, got.seq_length, got.bad_sequence);
            fail_count++;
        end else begin
            want = pending_points.pop_front();
            if (got.code_point !== want.code_point) begin
                $error("code_point: expected %h, got %h", want.code_point, got.code_point);
                fail_count++;
            end
            if (got.seq_length !== want.seq_length) begin
                $error("seq_length: expected %0d, got %0d", want.seq_length, got.seq_length);
                fail_count++;
            end
            if (got.bad_sequence !== want.bad_sequence) begin
                $error("bad_sequence: expected %0d, got %0d",
                       want.bad_sequence, got.bad_sequence);
                fail_count++;
            end
        end
        decoded_total++;
        if (got.bad_sequence === 1'b1)
            flagged_total++;
        if (got.seq_length >= 1 && got.seq_length <= 4)
            length_seen[got.seq_length]++;
    endtask

    // response side: random stalls, one quiet stretch with none,
    // and one long hold so the pipe fills and stalls the request side
    task automatic take_responses();
        int stall;
        forever begin
            if (decoded_total == HOLD_AT)
                stall = HOLD_CYCLES;
            else if (decoded_total >= 250 && decoded_total < 350)
                stall = 0;
            else
                stall = $urandom_range(0, 19);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            check_response(o_rsp);
        end
    endtask

    // watchdog on the whole run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("utf8_code_point_decoder_core_tb: errors");
        $finish;
    end

    initial begin
        t_in_req  win;
        t_out_req want;
        int       gap;
        fail_count    = 0;
        decoded_total = 0;
        flagged_total = 0;
        foreach (length_seen[n])
            length_seen[n] = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ready <= 1'b0;
        i_req   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            take_responses();
        join_none

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            win  = DIRECTED_ROWS[r].win;
            want = DIRECTED_ROWS[r].typed ? DIRECTED_ROWS[r].want : decode_window(win);
            offer_window(win, want, $urandom_range(0, 19));
        end

        // random windows; back-to-back stretches around the long hold and later on
        for (int k = 0; k < RANDOM_WINDOWS; k++) begin
            win = make_window();
            if (k < 120 || (k >= 400 && k < 460))
                gap = 0;
            else
                gap = $urandom_range(0, 19);
            offer_window(win, decode_window(win), gap);
        end
        i_valid <= 1'b0;

        // drain, then give any stray response time to show
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("decoded %0d windows, %0d flagged bad, in %0d cycles",
                 decoded_total, flagged_total, cycle_count);
        $display("sequence lengths 1/2/3/4: %0d/%0d/%0d/%0d, one long output hold",
                 length_seen[1], length_seen[2], length_seen[3], length_seen[4]);
        if (fail_count == 0)
            $display("utf8_code_point_decoder_core_tb: clean");
        else
            $display("utf8_code_point_decoder_core_tb: errors");
        $finish;
    end

endmodule
